@@ hdl/htk_pkg.sv @@
// Shared types and constants for the HTTP request tokenizer.
// Depends on nothing; imported by every module of the block.
package htk_pkg;

  // Field tags carried with every result word
  typedef enum logic [2:0] {
    FK_METHOD   = 3'd0,
    FK_PATH     = 3'd1,
    FK_QKEY     = 3'd2,
    FK_QVAL     = 3'd3,
    FK_VERSION  = 3'd4,
    FK_HNAME    = 3'd5,
    FK_HVAL     = 3'd6,
    FK_HDR_DONE = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_REQ  = 2'd0,
    PH_HDR  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    SF_METHOD  = 3'd0,
    SF_PATH    = 3'd1,
    SF_QUERY   = 3'd2,
    SF_VERSION = 3'd3,
    SF_NAME    = 3'd4,
    SF_SKIP    = 3'd5,
    SF_VALUE   = 3'd6
  } subfield_t;

  typedef enum logic [1:0] {
    QM_NONE  = 2'd0,
    QM_KEY   = 2'd1,
    QM_VALUE = 2'd2,
    QM_FRAG  = 2'd3
  } qmode_t;

  typedef enum logic [1:0] {
    ESC_IDLE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2,
    ESC_BAD    = 2'd3
  } esc_t;

  // Configuration register indexes
  localparam logic CFG_DEC_MIN = 1'b0;
  localparam logic CFG_DEC_MAX = 1'b1;

  localparam logic [7:0] DEC_MIN_RST = 8'h1F;
  localparam logic [7:0] DEC_MAX_RST = 8'h7E;

  // Characters with a meaning to the parser
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } in_word_t;

  typedef struct packed {
    kind_t      field_kind;
    logic [7:0] char_out;
    logic       char_valid;
    logic       field_end;
    logic       pair_end;
    logic       pair_kept;
    logic       last_result;
  } out_word_t;

  // Up to two result words produced by one byte
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  typedef struct packed {
    phase_t     phase;
    subfield_t  subfield;
    qmode_t     qmode;
    logic       pending_cr;
    esc_t       esc;
    logic [3:0] esc_high;
    logic       key_ne;
    logic       val_ne;
    logic       line_empty;
  } parse_state_t;

  localparam parse_state_t PARSE_RST = '{
    phase: PH_REQ, subfield: SF_METHOD, qmode: QM_NONE, pending_cr: 1'b0,
    esc: ESC_IDLE, esc_high: 4'h0, key_ne: 1'b0, val_ne: 1'b0, line_empty: 1'b1
  };

  // Build one result word; last_result is set later
  function automatic out_word_t mk_word(kind_t k, logic [7:0] c, logic v,
                                        logic fe, logic pe, logic pk);
    out_word_t w;
    w.field_kind  = k;
    w.char_out    = v ? c : 8'h00;
    w.char_valid  = v;
    w.field_end   = fe;
    w.pair_end    = pe;
    w.pair_kept   = pk;
    w.last_result = 1'b0;
    return w;
  endfunction

  // Hex digit decode: {is_hex, value}
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] r;
    r = 5'h00;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

endpackage

@@ hdl/htk_parse.sv @@
// Parse state and per-byte decode of the tokenizer.
// Depends on htk_pkg; produces up to two result words per stepped byte.
module htk_parse import htk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_word_t   word,
  input  logic [7:0] dec_min,
  input  logic [7:0] dec_max,
  output push_t      push
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  parse_state_t cur;
  out_word_t    res [2];
  logic [1:0]   n;
  logic [7:0]   b;
  logic [4:0]   hx;
  logic [7:0]   dv;
  logic         do_line;
  logic         do_plain;

  assign b  = word.data_byte;
  assign hx = hex_val(b);

  // Decode one byte against the current state
  always_comb begin
    cur      = word.new_request ? PARSE_RST : st_r;
    st_nxt   = cur;
    n        = 2'd0;
    res[0]   = '0;
    res[1]   = '0;
    do_line  = 1'b0;
    do_plain = 1'b0;
    dv       = 8'h00;

    if (cur.phase != PH_DONE) begin
      // line end detection: CR then LF
      if (cur.pending_cr) begin
        st_nxt.pending_cr = 1'b0;
        if (b == CH_LF) do_line = 1'b1;
        else if (b == CH_CR) st_nxt.pending_cr = 1'b1;
        else do_plain = 1'b1;
      end else if (b == CH_CR) begin
        st_nxt.pending_cr = 1'b1;
      end else begin
        do_plain = 1'b1;
      end

      if (do_line) begin
        if (st_nxt.phase == PH_REQ) begin
          // close the open request-line field
          unique case (st_nxt.subfield)
            SF_METHOD: begin
              res[n[0]] = mk_word(FK_METHOD, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
              n = n + 2'd1;
            end
            SF_PATH: begin
              res[n[0]] = mk_word(FK_PATH, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
              n = n + 2'd1;
            end
            SF_QUERY: begin
              if (st_nxt.qmode == QM_KEY || st_nxt.qmode == QM_VALUE) begin
                res[n[0]] = mk_word((st_nxt.qmode == QM_KEY) ? FK_QKEY : FK_QVAL,
                                    8'h00, 1'b0, 1'b1, 1'b1,
                                    st_nxt.qmode == QM_VALUE && st_nxt.key_ne
                                    && st_nxt.val_ne);
                n = n + 2'd1;
              end
            end
            default: begin
              res[n[0]] = mk_word(FK_VERSION, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
              n = n + 2'd1;
            end
          endcase
          st_nxt.phase      = PH_HDR;
          st_nxt.subfield   = SF_NAME;
          st_nxt.qmode      = QM_NONE;
          st_nxt.esc        = ESC_IDLE;
          st_nxt.line_empty = 1'b1;
        end else if (st_nxt.line_empty) begin
          // empty line: headers done
          st_nxt.phase = PH_DONE;
          res[n[0]] = mk_word(FK_HDR_DONE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
          n = n + 2'd1;
        end else begin
          // close header pair, with an empty value for a line without colon
          if (st_nxt.subfield == SF_NAME) begin
            res[n[0]] = mk_word(FK_HNAME, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            n = n + 2'd1;
          end
          res[n[0]] = mk_word(FK_HVAL, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
          n = n + 2'd1;
          st_nxt.subfield   = SF_NAME;
          st_nxt.line_empty = 1'b1;
        end
      end

      if (do_plain) begin
        if (st_nxt.phase == PH_REQ) begin
          unique case (st_nxt.subfield)
            SF_METHOD: begin
              if (b == CH_SP) begin
                st_nxt.subfield = SF_PATH;
                res[n[0]] = mk_word(FK_METHOD, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
              end else begin
                res[n[0]] = mk_word(FK_METHOD, b, 1'b1, 1'b0, 1'b0, 1'b0);
              end
              n = n + 2'd1;
            end
            SF_PATH: begin
              if (b == CH_SP) begin
                st_nxt.subfield = SF_VERSION;
                res[n[0]] = mk_word(FK_PATH, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
              end else if (b == CH_QUEST) begin
                st_nxt.subfield = SF_QUERY;
                st_nxt.qmode    = QM_KEY;
                st_nxt.key_ne   = 1'b0;
                st_nxt.val_ne   = 1'b0;
                st_nxt.esc      = ESC_IDLE;
                res[n[0]] = mk_word(FK_PATH, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
              end else begin
                res[n[0]] = mk_word(FK_PATH, b, 1'b1, 1'b0, 1'b0, 1'b0);
              end
              n = n + 2'd1;
            end
            SF_QUERY: begin
              if (b == CH_SP || (st_nxt.esc == ESC_IDLE && st_nxt.qmode != QM_FRAG
                                 && b == CH_HASH)) begin
                // close the query at a space or a fragment mark
                if (b == CH_SP) st_nxt.subfield = SF_VERSION;
                if (st_nxt.qmode == QM_KEY || st_nxt.qmode == QM_VALUE) begin
                  res[n[0]] = mk_word((st_nxt.qmode == QM_KEY) ? FK_QKEY : FK_QVAL,
                                      8'h00, 1'b0, 1'b1, 1'b1,
                                      st_nxt.qmode == QM_VALUE && st_nxt.key_ne
                                      && st_nxt.val_ne);
                  n = n + 2'd1;
                end
                st_nxt.esc   = ESC_IDLE;
                st_nxt.qmode = QM_FRAG;
              end else if (st_nxt.esc == ESC_FIRST) begin
                // first escape digit
                if (hx[4]) begin
                  st_nxt.esc_high = hx[3:0];
                  st_nxt.esc      = ESC_SECOND;
                end else begin
                  st_nxt.esc = ESC_BAD;
                end
              end else if (st_nxt.esc != ESC_IDLE) begin
                // second escape digit: decode and range check
                if (st_nxt.esc == ESC_SECOND) begin
                  dv = hx[4] ? {st_nxt.esc_high, hx[3:0]} : {4'h0, st_nxt.esc_high};
                end
                st_nxt.esc = ESC_IDLE;
                if (dv >= dec_min && dv <= dec_max) begin
                  st_nxt.val_ne = 1'b1;
                  res[n[0]] = mk_word(FK_QVAL, dv, 1'b1, 1'b0, 1'b0, 1'b0);
                  n = n + 2'd1;
                end
              end else if (st_nxt.qmode == QM_FRAG) begin
                // drop fragment bytes
              end else if (st_nxt.qmode == QM_KEY) begin
                if (b == CH_EQ) begin
                  st_nxt.qmode = QM_VALUE;
                  res[n[0]] = mk_word(FK_QKEY, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                end else begin
                  st_nxt.key_ne = 1'b1;
                  res[n[0]] = mk_word(FK_QKEY, b, 1'b1, 1'b0, 1'b0, 1'b0);
                end
                n = n + 2'd1;
              end else if (b == CH_AMP) begin
                st_nxt.qmode  = QM_KEY;
                st_nxt.key_ne = 1'b0;
                st_nxt.val_ne = 1'b0;
                res[n[0]] = mk_word(FK_QVAL, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
                n = n + 2'd1;
              end else if (b == CH_PCT) begin
                st_nxt.esc = ESC_FIRST;
              end else begin
                st_nxt.val_ne = 1'b1;
                res[n[0]] = mk_word(FK_QVAL, (b == CH_PLUS) ? CH_SP : b,
                                    1'b1, 1'b0, 1'b0, 1'b0);
                n = n + 2'd1;
              end
            end
            default: begin
              res[n[0]] = mk_word(FK_VERSION, b, 1'b1, 1'b0, 1'b0, 1'b0);
              n = n + 2'd1;
            end
          endcase
        end else begin
          // header line byte
          st_nxt.line_empty = 1'b0;
          if (st_nxt.subfield == SF_NAME) begin
            if (b == CH_COLON) begin
              st_nxt.subfield = SF_SKIP;
              res[n[0]] = mk_word(FK_HNAME, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            end else begin
              res[n[0]] = mk_word(FK_HNAME, b, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            n = n + 2'd1;
          end else if (st_nxt.subfield == SF_SKIP && b == CH_SP) begin
            // skip leading spaces of the value
          end else begin
            st_nxt.subfield = SF_VALUE;
            res[n[0]] = mk_word(FK_HVAL, b, 1'b1, 1'b0, 1'b0, 1'b0);
            n = n + 2'd1;
          end
        end
      end
    end

    // mark the last word of this byte
    if (n == 2'd1) res[0].last_result = 1'b1;
    if (n == 2'd2) res[1].last_result = 1'b1;
  end

  assign push.cnt = step ? n : 2'd0;
  assign push.w0  = res[0];
  assign push.w1  = res[1];

  // Advance parse state on each stepped byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PARSE_RST;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ hdl/htk_outq.sv @@
// Four-word result queue: takes up to two words a cycle, hands out one unless stalled.
// Depends on htk_pkg for the word and push types.
module htk_outq import htk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  out_word_t  mem [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] wr_ptr_nxt;
  logic [1:0] rd_ptr_r;
  logic [1:0] rd_ptr_nxt;
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for a full two-word push
  assign room      = (cnt_r <= 3'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  // Write pushed words
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr_r] <= push.w0;
    if (push.cnt == 2'd2) mem[wr_ptr_r + 2'd1] <= push.w1;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ hdl/http_request_tokenizer.sv @@
// Top level of the HTTP request tokenizer: input register, config, queue.
// Depends on htk_pkg, htk_parse and htk_outq.
//
//  channel | direction | handshake        | word
//  in_     | input     | in_valid/stall   | in_word_t  (data_byte, new_request)
//  out_    | output    | out_valid/stall  | out_word_t (tagged field character)
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// One byte a cycle while the input does not stall: a byte is held in the input
// register, is decoded there and its zero to two result words enter a four-word queue.
// A byte with two results pushes one word more than the output takes; the queue absorbs it.
// Input stalls only while a byte waits and the queue has less than two free.
// Synchronous active-low reset clears parse state, queue and config.
module http_request_tokenizer import htk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  in_word_t   s1_word_r;
  logic [7:0] dec_min_r;
  logic [7:0] dec_max_r;
  logic       room;
  logic       step;
  logic       in_acc;
  push_t      push;

  assign cfg_ready = 1'b1;
  assign step      = s1_valid_r && room;
  assign in_stall  = s1_valid_r && !room;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (step) s1_valid_nxt = 1'b0;
  end

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_word_r <= in_data;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_min_r <= DEC_MIN_RST;
      dec_max_r <= DEC_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEC_MIN: dec_min_r <= cfg_data;
        CFG_DEC_MAX: dec_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  htk_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .word    (s1_word_r),
    .dec_min (dec_min_r),
    .dec_max (dec_max_r),
    .push    (push)
  );

  htk_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
